// ----- src/prps_pkg.sv -----
// Shared types, constants and the cosine table of the point splat block.
package prps_pkg;

  localparam int CellWidthDef  = 106;
  localparam int CellHeightDef = 120;
  localparam int FrameColsDef  = 1920;
  localparam int FrameRowsDef  = 1080;
  localparam int QueueDepthDef = 4;

  localparam int ANGLE_STEPS = 72;
  localparam int ROM_SIZE    = 72;
  localparam int QUARTER     = ROM_SIZE / 4;

  localparam int COORD_W = 16;   // model coordinate width
  localparam int TRIG_W  = 10;   // Q8 cos/sin, +-256
  localparam int PROD_W  = COORD_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ROT_W   = SUM_W - 8;
  localparam int SCR_W   = 20;   // cell-relative coordinate, signed
  localparam int POS_W   = 16;   // frame position before the 11-bit mask
  localparam int PIX_W   = 11;
  localparam int ANG_W   = 7;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW   = 2'd2;

  localparam logic signed [TRIG_W-1:0] COS_ROM [ROM_SIZE] = '{
    10'sd256, 10'sd255, 10'sd252, 10'sd247, 10'sd241, 10'sd232,
    10'sd222, 10'sd210, 10'sd196, 10'sd181, 10'sd165, 10'sd147,
    10'sd128, 10'sd108, 10'sd88, 10'sd66, 10'sd44, 10'sd22,
    10'sd0, -10'sd22, -10'sd44, -10'sd66, -10'sd88, -10'sd108,
    -10'sd128, -10'sd147, -10'sd165, -10'sd181, -10'sd196, -10'sd210,
    -10'sd222, -10'sd232, -10'sd241, -10'sd247, -10'sd252, -10'sd255,
    -10'sd256, -10'sd255, -10'sd252, -10'sd247, -10'sd241, -10'sd232,
    -10'sd222, -10'sd210, -10'sd196, -10'sd181, -10'sd165, -10'sd147,
    -10'sd128, -10'sd108, -10'sd88, -10'sd66, -10'sd44, -10'sd22,
    10'sd0, 10'sd22, 10'sd44, 10'sd66, 10'sd88, 10'sd108,
    10'sd128, 10'sd147, 10'sd165, 10'sd181, 10'sd196, 10'sd210,
    10'sd222, 10'sd232, 10'sd241, 10'sd247, 10'sd252, 10'sd255
  };

  // One classified point: base pixel, which of the 2x2 pixels land in frame.
  typedef struct packed {
    logic [PIX_W-1:0] x0;
    logic [PIX_W-1:0] y0;
    logic [3:0]       mask;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } prps_job_t;

endpackage

// ----- src/point_rotate_project_splat_core.sv -----
// Point splatter: rotate about y, project into a slice cell, emit a 2x2 pixel block.
//
// Input stream (s_axis): one model point per item; tlast marks the model's last point.
// Output stream (m_axis): one item per pixel written, up to four per point, in the order
//   (x,y), (x+1,y), (x,y+1), (x+1,y+1); tlast closes each point's run. A point that
//   lands outside the cell gives no item, except the last point of the model, which then
//   gives one item with pixel_valid low and zero coordinates and colour.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 angle step,
//   1 slice column, 2 slice row); write only while the block is drained.
// Path: stage 1 and stage 2 registers, the job queue, then the emitter output register.
// Throughput: the front end takes one point per cycle unless stalled; the emitter sends
//   one item per cycle while m_axis accepts, one per pixel (one for the dummy item),
//   four for a full splat. The queue lets the front end run ahead while m_axis stalls.
// Reset: control and config registers clear, queue empty, angle 0, cell (0,0).
// Stall: a held m_axis item stays stable; a full queue backs up to s_axis_tready.
module point_rotate_project_splat_core import prps_pkg::*; #(
  parameter int CELL_WIDTH  = CellWidthDef,
  parameter int CELL_HEIGHT = CellHeightDef,
  parameter int FRAME_COLS  = FrameColsDef,
  parameter int FRAME_ROWS  = FrameRowsDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_x, point_y, point_z, point_red, point_green, point_blue
  input  logic [71:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,   // last_point
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, 2 zero bits
  output logic [47:0]           m_axis_tdata,
  // pixel_valid, model_done
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast    // run_last
);

  logic      push, queue_ready, job_valid, job_pop;
  prps_job_t job_in, job_head;

  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic [23:0]      pixel_rgb;
  logic             pixel_valid, model_done;

  prps_front #(
    .CELL_WIDTH  (CELL_WIDTH),
    .CELL_HEIGHT (CELL_HEIGHT),
    .FRAME_COLS  (FRAME_COLS),
    .FRAME_ROWS  (FRAME_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .job_valid_o (push),
    .job_ready_i (queue_ready),
    .job_o       (job_in)
  );

  prps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (queue_ready),
    .data_i  (job_in),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .data_o  (job_head)
  );

  prps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_rgb_o   (pixel_rgb),
    .pixel_valid_o (pixel_valid),
    .model_done_o  (model_done),
    .run_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, pixel_rgb, pixel_y, pixel_x};
  assign m_axis_tuser = {model_done, pixel_valid};

endmodule

// ----- src/prps_front.sv -----
// Front end: config registers, rotation, projection and 2x2 clip classification.
module prps_front import prps_pkg::*; #(
  parameter int CELL_WIDTH  = CellWidthDef,
  parameter int CELL_HEIGHT = CellHeightDef,
  parameter int FRAME_COLS  = FrameColsDef,
  parameter int FRAME_ROWS  = FrameRowsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [71:0]           in_data_i,
  input  logic                  in_last_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output prps_job_t             job_o
);

  logic [ANG_W-1:0] angle_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE: angle_q <= cfg_wdata_i[ANG_W-1:0];
        CFG_COL:   col_q   <= cfg_wdata_i[COL_W-1:0];
        CFG_ROW:   row_q   <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // table lookup; sine is cosine a quarter turn back
  logic [ANG_W-1:0]          ang;
  logic [ANG_W:0]            sin_sum;
  logic [ANG_W-1:0]          sin_idx;
  logic signed [TRIG_W-1:0]  cos_v, sin_v;

  always_comb begin
    ang = ((angle_q < ANG_W'(ANGLE_STEPS)) && (angle_q < ANG_W'(ROM_SIZE))) ? angle_q : '0;
    sin_sum = {1'b0, ang} + (ANG_W+1)'(ROM_SIZE - QUARTER);
    sin_idx = (sin_sum >= (ANG_W+1)'(ROM_SIZE)) ? ANG_W'(sin_sum - (ANG_W+1)'(ROM_SIZE))
                                              : ANG_W'(sin_sum);
    cos_v = COS_ROM[ang];
    sin_v = COS_ROM[sin_idx];
  end

  logic signed [COORD_W-1:0] px, py, pz;
  assign px = in_data_i[15:0];
  assign py = in_data_i[31:16];
  assign pz = in_data_i[47:32];

  // stage 1: products
  logic                      s1_valid_q;
  logic signed [PROD_W-1:0]  prod_x_q, prod_z_q;
  logic signed [COORD_W-1:0] py1_q;
  logic [23:0]               rgb1_q;
  logic                      last1_q;

  // stage 2: cell-relative position
  logic                      s2_valid_q;
  logic                      in_cell_q;
  logic [POS_W-1:0]          sx_q, sy_q;
  logic [23:0]               rgb2_q;
  logic                      last2_q;

  logic s1_adv, s2_adv, need_push;

  assign s2_adv     = !s2_valid_q || !need_push || job_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      prod_x_q <= PROD_W'(px) * PROD_W'(cos_v);
      prod_z_q <= PROD_W'(pz) * PROD_W'(sin_v);
      py1_q    <= py;
      rgb1_q   <= in_data_i[71:48];
      last1_q  <= in_last_i;
    end
  end

  logic signed [SUM_W-1:0] sum;
  logic signed [ROT_W-1:0] rx;
  logic signed [SCR_W-1:0] sx, sy;
  logic                    in_cell;

  always_comb begin
    sum = SUM_W'(prod_x_q) + SUM_W'(prod_z_q);
    rx  = sum[SUM_W-1:8];   // floor divide by 256
    sx  = SCR_W'(rx) + SCR_W'(CELL_WIDTH / 2);
    sy  = SCR_W'(CELL_HEIGHT / 2) - SCR_W'(py1_q);
    in_cell = (sx >= 0) && (sx < SCR_W'(CELL_WIDTH)) &&
              (sy >= 0) && (sy < SCR_W'(CELL_HEIGHT));
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      in_cell_q <= in_cell;
      sx_q      <= sx[POS_W-1:0];
      sy_q      <= sy[POS_W-1:0];
      rgb2_q    <= rgb1_q;
      last2_q   <= last1_q;
    end
  end

  // classify the 2x2 block against the frame
  logic [POS_W-1:0] x0, y0, x1, y1;
  logic             xin0, xin1, yin0, yin1;
  logic [3:0]       mask;

  always_comb begin
    x0   = POS_W'(CELL_WIDTH) * POS_W'(col_q) + sx_q;
    y0   = POS_W'(CELL_HEIGHT) * POS_W'(row_q) + sy_q;
    x1   = x0 + POS_W'(1);
    y1   = y0 + POS_W'(1);
    xin0 = x0 < POS_W'(FRAME_COLS);
    xin1 = x1 < POS_W'(FRAME_COLS);
    yin0 = y0 < POS_W'(FRAME_ROWS);
    yin1 = y1 < POS_W'(FRAME_ROWS);
    mask = in_cell_q ? {xin1 & yin1, xin0 & yin1, xin1 & yin0, xin0 & yin0} : 4'b0000;
    need_push = (mask != 4'b0000) || last2_q;
  end

  assign job_valid_o = s2_valid_q && need_push;
  assign job_o.x0    = x0[PIX_W-1:0];
  assign job_o.y0    = y0[PIX_W-1:0];
  assign job_o.mask  = mask;
  assign job_o.red   = rgb2_q[7:0];
  assign job_o.green = rgb2_q[15:8];
  assign job_o.blue  = rgb2_q[23:16];
  assign job_o.last  = last2_q;

endmodule

// ----- src/prps_fifo.sv -----
// Short job queue between the classifying front end and the pixel emitter.
module prps_fifo import prps_pkg::*; #(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      ready_o,
  input  prps_job_t data_i,
  output logic      valid_o,
  input  logic      pop_i,
  output prps_job_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  prps_job_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign ready_o = count_q != CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- src/prps_back.sv -----
// Back end: walks queued 2x2 masks; a pixel item per cycle unless held.
module prps_back import prps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  prps_job_t        job_i,
  output logic             job_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] pixel_x_o,
  output logic [PIX_W-1:0] pixel_y_o,
  output logic [23:0]      pixel_rgb_o,
  output logic             pixel_valid_o,
  output logic             model_done_o,
  output logic             run_last_o
);

  logic [3:0] done_q;
  logic [3:0] rem, pick, rem_next;
  logic [1:0] sel;
  logic       drawn, load, final_px;

  always_comb begin
    rem  = job_i.mask & ~done_q;
    pick = rem & (~rem + 4'd1);   // lowest set bit
    sel  = {pick[3] | pick[2], pick[3] | pick[1]};
    rem_next = rem & ~pick;
    drawn    = job_i.mask != 4'b0000;
    final_px = rem_next == 4'b0000;
    load     = job_valid_i && (!out_valid_o || out_ready_i);
  end

  assign job_pop_o = load && final_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (load) done_q <= final_px ? 4'b0000 : (done_q | pick);
      if (load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_x_o     <= drawn ? job_i.x0 + PIX_W'(sel[0]) : '0;
      pixel_y_o     <= drawn ? job_i.y0 + PIX_W'(sel[1]) : '0;
      pixel_rgb_o   <= drawn ? {job_i.blue, job_i.green, job_i.red} : '0;
      pixel_valid_o <= drawn;
      model_done_o  <= job_i.last;
      run_last_o    <= final_px;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for point_rotate_project_splat_core: stream driver, pixel predictor.
`timescale 1ns / 1ps

module tb_top;
  import prps_pkg::*;

  localparam int CELL_W  = 106;
  localparam int CELL_H  = 120;
  localparam int FRAME_W = 1920;
  localparam int FRAME_H = 1080;
  localparam int STEPS   = 72;
  localparam int SETTLE_CYCLES = 8;   // settle margin after the pending queue empties
  localparam int IDLE_PCT = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index, must be ignored

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } point_t;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        valid;
    logic        done;
    logic        last;
  } pixel_t;

  class splat_scoreboard;
    pixel_t      pending_q[$];
    int unsigned n_mismatch;
    logic [6:0]  angle;
    logic [3:0]  col;
    logic [2:0]  row;

    function new();
      n_mismatch = 0;
      angle = '0;
      col   = '0;
      row   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ANGLE: angle = val;
        CFG_COL:   col   = val[3:0];
        CFG_ROW:   row   = val[2:0];
        default: ;
      endcase
    endfunction

    // Q8 cosine built from the first quadrant; sine is cosine shifted by 3/4 turn
    function int cos_q8(int a);
      int quarter[19];
      quarter = '{256, 255, 252, 247, 241, 232, 222, 210, 196, 181,
                  165, 147, 128, 108, 88, 66, 44, 22, 0};
      if (a <= 18) return quarter[a];
      else if (a <= 36) return -quarter[36 - a];
      else if (a <= 54) return -quarter[a - 36];
      else return quarter[72 - a];
    endfunction

    function void note_point(point_t p);
      pixel_t run[4];
      pixel_t pix;
      int step, c, s, px, py, pz, rx, sx, sy, x0, y0, xi, yi, n, i;
      step = (int'(angle) >= STEPS) ? 0 : int'(angle);
      c  = cos_q8(step);
      s  = cos_q8((step + 54) % STEPS);
      px = $signed(p.x);
      py = $signed(p.y);
      pz = $signed(p.z);
      rx = (px * c + pz * s) >>> 8;   // floor division by 256
      sx = CELL_W / 2 + rx;
      sy = CELL_H / 2 - py;
      n  = 0;
      if (sx >= 0 && sx < CELL_W && sy >= 0 && sy < CELL_H) begin
        x0 = int'(col) * CELL_W + sx;
        y0 = int'(row) * CELL_H + sy;
        for (i = 0; i < 4; i++) begin
          xi = x0 + (i & 1);
          yi = y0 + (i >> 1);
          if (xi < FRAME_W && yi < FRAME_H) begin
            pix.x     = 11'(xi);
            pix.y     = 11'(yi);
            pix.red   = p.red;
            pix.green = p.green;
            pix.blue  = p.blue;
            pix.valid = 1'b1;
            pix.done  = p.last;
            pix.last  = 1'b0;
            run[n] = pix;
            n++;
          end
        end
      end
      // last point of the model always closes with one item
      if (n == 0 && p.last) begin
        pix = '0;
        pix.done = 1'b1;
        run[0] = pix;
        n = 1;
      end
      if (n > 0) run[n-1].last = 1'b1;
      for (i = 0; i < n; i++) pending_q.push_back(run[i]);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: pixel with none pending: x=%0d y=%0d valid=%0b done=%0b last=%0b",
                   $realtime, got.x, got.y, got.valid, got.done, got.last);
        return;
      end
      want = pending_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.valid !== want.valid || got.done !== want.done || got.last !== want.last) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("%0t: pixel mismatch", $realtime);
          $display("  expected x=%0d y=%0d rgb=%02h_%02h_%02h valid=%0b done=%0b last=%0b",
                   want.x, want.y, want.red, want.green, want.blue,
                   want.valid, want.done, want.last);
          $display("  actual   x=%0d y=%0d rgb=%02h_%02h_%02h valid=%0b done=%0b last=%0b",
                   got.x, got.y, got.red, got.green, got.blue,
                   got.valid, got.done, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // point_x, point_y, point_z, point_red, point_green, point_blue
  logic [71:0]           s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;   // last_point
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, 2 zero bits
  logic [47:0]           m_axis_tdata;
  // pixel_valid, model_done
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;          // run_last

  bit gaps_on = 1'b1;
  int rx_hold = 0;
  splat_scoreboard sb = new();

  point_rotate_project_splat_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

  // pixel sink: check each accepted item, then pick the next ready level
  initial begin
    pixel_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.x     = m_axis_tdata[10:0];
        got.y     = m_axis_tdata[21:11];
        got.red   = m_axis_tdata[29:22];
        got.green = m_axis_tdata[37:30];
        got.blue  = m_axis_tdata[45:38];
        got.valid = m_axis_tuser[0];
        got.done  = m_axis_tuser[1];
        got.last  = m_axis_tlast;
        sb.check_pixel(got);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic point_t mk_point(int x, int y, int z, int r, int g, int b, bit last);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.z = 16'(z);
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.last = last;
    return p;
  endfunction

  // mostly points near the cell center, some anywhere in the coordinate range
  function automatic point_t rand_point();
    point_t p;
    if ($urandom_range(99) < 75) begin
      p.x = 16'(int'($urandom_range(90)) - 45);
      p.y = 16'(int'($urandom_range(130)) - 65);
      p.z = 16'(int'($urandom_range(90)) - 45);
    end else begin
      p.x = 16'($urandom());
      p.y = 16'($urandom());
      p.z = 16'($urandom());
    end
    p.red   = 8'($urandom_range(255));
    p.green = 8'($urandom_range(255));
    p.blue  = 8'($urandom_range(255));
    p.last  = ($urandom_range(99) < 8);
    return p;
  endfunction

  task automatic send_point(point_t p);
    s_axis_tdata  <= {p.blue, p.green, p.red, p.z, p.y, p.x};
    s_axis_tlast  <= p.last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_point(p);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    // points that land outside the cell leave nothing to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_cell(logic [6:0] angle, logic [3:0] col, logic [2:0] row);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ANGLE;
    cfg_wdata_i <= angle;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_COL;
    cfg_wdata_i <= CFG_DATA_W'(col);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ROW;
    cfg_wdata_i <= CFG_DATA_W'(row);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SPARE;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(CFG_ANGLE, angle);
    sb.write_reg(CFG_COL, CFG_DATA_W'(col));
    sb.write_reg(CFG_ROW, CFG_DATA_W'(row));
    sb.write_reg(CFG_SPARE, junk);
  endtask

  task automatic run_phase(logic [6:0] angle, logic [3:0] col, logic [2:0] row,
                           int n_pts, bit mid_pause);
    int i;
    set_cell(angle, col, row);
    for (i = 0; i < n_pts; i++) begin
      send_point(rand_point());
      if (mid_pause && i == n_pts / 2) begin
        s_axis_tvalid <= 1'b0;
        drain();
      end
    end
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    point_t directed[$];
    int i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no rotation, cell (0,0), so sx = 53 + x, sy = 60 - y
    directed.push_back(mk_point(-53, 60, 0, 0, 0, 0, 0));        // top-left corner of cell
    directed.push_back(mk_point(52, -59, 0, 255, 255, 255, 0));  // bottom-right corner
    directed.push_back(mk_point(-54, 0, 0, 1, 2, 3, 0));         // just left of cell
    directed.push_back(mk_point(53, 0, 0, 4, 5, 6, 0));          // just right
    directed.push_back(mk_point(0, 61, 0, 7, 8, 9, 0));          // just above
    directed.push_back(mk_point(0, -60, 0, 10, 11, 12, 0));      // just below
    directed.push_back(mk_point(32767, 32767, 32767, 8'h55, 8'h55, 8'h55, 0));
    directed.push_back(mk_point(-32768, -32768, -32768, 8'haa, 8'haa, 8'haa, 0));
    directed.push_back(mk_point(0, 0, -32768, 8'h0f, 8'hf0, 8'h3c, 0));
    directed.push_back(mk_point(0, 0, 32767, 8'hf0, 8'h0f, 8'hc3, 0));
    directed.push_back(mk_point(-1, -1, -1, 8'h81, 8'h42, 8'h24, 0));
    directed.push_back(mk_point(5, 5, 5, 8'h12, 8'h34, 8'h56, 1));   // drawn last point
    directed.push_back(mk_point(200, 0, 0, 8'h9a, 8'hbc, 8'hde, 1)); // last, nothing drawn
    directed.push_back(mk_point(-32768, 0, 0, 8'hff, 8'h00, 8'hff, 1));
    for (i = 0; i < directed.size(); i++) send_point(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain();

    // sink holds off long enough for the job queue to fill and stall the input
    rx_hold = 80;
    run_phase(7'd71, 4'd11, 3'd5, 22, 1'b0);
    gaps_on = 1'b0;
    run_phase(7'd72, 4'd15, 3'd7, 22, 1'b0);
    gaps_on = 1'b1;
    run_phase(7'd127, 4'd0, 3'd0, 22, 1'b1);
    run_phase(7'd18, 4'd5, 3'd3, 22, 1'b0);
    run_phase(7'd36, 4'd11, 3'd0, 22, 1'b0);
    run_phase(7'd54, 4'd0, 3'd5, 22, 1'b0);
    run_phase(7'($urandom_range(71)), 4'($urandom_range(11)), 3'($urandom_range(5)), 22, 1'b1);
    run_phase(7'($urandom_range(127)), 4'($urandom_range(15)), 3'($urandom_range(7)), 22, 1'b0);

    if (sb.n_mismatch == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/prps_pkg.sv
src/prps_front.sv
src/prps_fifo.sv
src/prps_back.sv
src/point_rotate_project_splat_core.sv
tb/tb_top.sv
